[rtl/bbff_pkg.sv]
// package for the bitmap first-fit block allocator
// holds map geometry, payload structs, codes and internal bus types
// no dependencies
package bbff_pkg;

    localparam int MAP_BLOCKS = 4096;
    localparam int WORD_BITS  = 64;
    localparam int MAP_WORDS  = MAP_BLOCKS / WORD_BITS;
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int BIT_AW     = $clog2(WORD_BITS);
    localparam int BLK_W      = 12;
    localparam int CFG_W      = 13;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic [CFG_W-1:0] SCAN_LIMIT_MAX = CFG_W'(MAP_BLOCKS);

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_IGNORED = 2'd2
    } status_t;

    typedef enum logic {
        REG_DATA_START  = 1'b0,
        REG_BLOCK_COUNT = 1'b1
    } reg_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        req_type_t        req_type;
        logic [BLK_W-1:0] block_index;
    } alloc_req_t;

    typedef struct packed {
        logic [BLK_W-1:0] result_block;
        status_t          status;
    } alloc_rsp_t;

    typedef struct packed {
        logic               en;
        logic [WORD_AW-1:0] addr;
    } map_rd_t;

    typedef struct packed {
        logic                 en;
        logic [WORD_AW-1:0]   addr;
        logic [WORD_BITS-1:0] data;
    } map_wr_t;

    typedef struct packed {
        logic              found;
        logic [BIT_AW-1:0] bit_idx;
    } find_res_t;

endpackage

[rtl/bbff_map.sv]
// used-map storage: one word of used bits per row, registered read port
// rows carry valid bits cleared by reset, an invalid row reads as all clear
// depends on bbff_pkg
module bbff_map (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bbff_pkg::map_rd_t             rd,
    output logic [bbff_pkg::WORD_BITS-1:0] rd_data,
    input  bbff_pkg::map_wr_t             wr
);
    import bbff_pkg::*;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_q_reg;
    logic [MAP_WORDS-1:0] row_valid_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_q_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (wr.en) begin
                row_valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en) begin
                rd_valid_reg <= row_valid_reg[rd.addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

[rtl/bbff_word_find.sv]
// word evaluator: masks one map word to the scan range and finds the lowest clear bit
// also forms the word with that bit set
// depends on bbff_pkg
module bbff_word_find (
    input  logic [bbff_pkg::WORD_BITS-1:0] word_data,
    input  logic [bbff_pkg::WORD_AW-1:0]   word_addr,
    input  logic [bbff_pkg::WORD_AW-1:0]   first_word,
    input  logic [bbff_pkg::WORD_AW-1:0]   last_word,
    input  logic [bbff_pkg::BIT_AW-1:0]    lo_bit,
    input  logic [bbff_pkg::BIT_AW-1:0]    hi_bit,
    output bbff_pkg::find_res_t            res,
    output logic [bbff_pkg::WORD_BITS-1:0] set_word
);
    import bbff_pkg::*;

    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] clear_bits;
    logic [WORD_BITS-1:0] iso;
    logic [BIT_AW-1:0]    idx;

    always_comb begin
        lo_mask = (word_addr == first_word) ? ({WORD_BITS{1'b1}} << lo_bit)
                                            : {WORD_BITS{1'b1}};
        hi_mask = (word_addr == last_word)
                ? ({WORD_BITS{1'b1}} >> (BIT_AW'(WORD_BITS - 1) - hi_bit))
                : {WORD_BITS{1'b1}};
        clear_bits = ~word_data & lo_mask & hi_mask;
        // isolate lowest set bit
        iso = clear_bits & (~clear_bits + WORD_BITS'(1));
        for (int k = 0; k < BIT_AW; k++) begin
            idx[k] = 1'b0;
            for (int b = 0; b < WORD_BITS; b++) begin
                if (((b >> k) & 1) == 1) begin
                    idx[k] = idx[k] | iso[b];
                end
            end
        end
        res.found   = |clear_bits;
        res.bit_idx = idx;
        set_word    = word_data | iso;
    end

endmodule

[rtl/block_bitmap_first_fit_alloc_unit.sv]
// bitmap first-fit block allocator, top level with sequencer and register port
// to result register: free in range reads then writes back its word, ignored free or empty-range allocate
// goes straight to done, allocate scans n map words (1 to 64, one 64-bit word per cycle, one read port)
// one request at a time; s_ready returns the cycle after the result register loads
// synchronous active-low reset clears the map at once through per-row valid bits
// depends on bbff_pkg, bbff_map, bbff_word_find
module block_bitmap_first_fit_alloc_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bbff_pkg::alloc_req_t          s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bbff_pkg::alloc_rsp_t          m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bbff_pkg::APB_AW-1:0]   paddr,
    input  logic [bbff_pkg::APB_DW-1:0]   pwdata,
    output logic [bbff_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import bbff_pkg::*;

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   data_start_reg;
    logic [CFG_W-1:0]   block_count_reg;
    logic [WORD_AW-1:0] word_reg, word_next;
    logic               more_reg, more_next;
    logic               pend_reg, pend_next;
    logic [WORD_AW-1:0] pend_word_reg, pend_word_next;
    logic [BIT_AW-1:0]  bit_reg, bit_next;
    alloc_rsp_t         res_reg, res_next;
    logic               m_valid_reg;
    alloc_rsp_t         m_data_reg;

    logic [CFG_W-1:0]     lim;
    logic [CFG_W-1:0]     lim_m1;
    logic                 empty_range;
    logic [WORD_AW-1:0]   first_word;
    logic [WORD_AW-1:0]   last_word;
    logic                 accept;
    logic                 free_in_range;
    logic                 load_out;
    map_rd_t              map_rd;
    map_wr_t              map_wr;
    logic [WORD_BITS-1:0] rd_data;
    find_res_t            find;
    logic [WORD_BITS-1:0] set_word;
    reg_sel_t             reg_sel;
    logic                 cfg_wr;

    // register port
    assign pready  = 1'b1;
    assign reg_sel = reg_sel_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_start_reg  <= '0;
            block_count_reg <= SCAN_LIMIT_MAX;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_DATA_START:  data_start_reg  <= pwdata[CFG_W-1:0];
                REG_BLOCK_COUNT: block_count_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_DATA_START:  prdata = APB_DW'(data_start_reg);
            REG_BLOCK_COUNT: prdata = APB_DW'(block_count_reg);
            default:         prdata = '0;
        endcase
    end

    // scan range
    assign lim         = (block_count_reg > SCAN_LIMIT_MAX) ? SCAN_LIMIT_MAX : block_count_reg;
    assign lim_m1      = lim - CFG_W'(1);
    assign empty_range = data_start_reg >= lim;
    assign first_word  = data_start_reg[BIT_AW +: WORD_AW];
    assign last_word   = lim_m1[BIT_AW +: WORD_AW];

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign free_in_range = (CFG_W'(s_data.block_index) >= data_start_reg)
                        && (CFG_W'(s_data.block_index) < lim);
    assign load_out      = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    bbff_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (map_rd),
        .rd_data (rd_data),
        .wr      (map_wr)
    );

    bbff_word_find u_find (
        .word_data  (rd_data),
        .word_addr  (pend_word_reg),
        .first_word (first_word),
        .last_word  (last_word),
        .lo_bit     (data_start_reg[BIT_AW-1:0]),
        .hi_bit     (lim_m1[BIT_AW-1:0]),
        .res        (find),
        .set_word   (set_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            more_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            more_reg  <= more_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg      <= word_next;
        pend_word_reg <= pend_word_next;
        bit_reg       <= bit_next;
        res_reg       <= res_next;
    end

    always_comb begin
        state_next     = state_reg;
        word_next      = word_reg;
        more_next      = more_reg;
        pend_next      = 1'b0;
        pend_word_next = pend_word_reg;
        bit_next       = bit_reg;
        res_next       = res_reg;
        map_rd.en      = 1'b0;
        map_rd.addr    = word_reg;
        map_wr.en      = 1'b0;
        map_wr.addr    = pend_word_reg;
        map_wr.data    = set_word;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.req_type == REQ_ALLOC) begin
                        if (empty_range) begin
                            res_next.result_block = '0;
                            res_next.status       = STAT_FULL;
                            state_next            = ST_DONE;
                        end else begin
                            word_next  = first_word;
                            more_next  = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end else begin
                        res_next.result_block = s_data.block_index;
                        if (free_in_range) begin
                            map_rd.en      = 1'b1;
                            map_rd.addr    = s_data.block_index[BIT_AW +: WORD_AW];
                            pend_word_next = s_data.block_index[BIT_AW +: WORD_AW];
                            bit_next       = s_data.block_index[BIT_AW-1:0];
                            res_next.status = STAT_DONE;
                            state_next     = ST_FREE_WR;
                        end else begin
                            res_next.status = STAT_IGNORED;
                            state_next      = ST_DONE;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // issue next word read while the previous word is evaluated
                if (more_reg) begin
                    map_rd.en      = 1'b1;
                    pend_next      = 1'b1;
                    pend_word_next = word_reg;
                    word_next      = word_reg + WORD_AW'(1);
                    more_next      = (word_reg != last_word);
                end
                if (pend_reg) begin
                    if (find.found) begin
                        map_wr.en             = 1'b1;
                        res_next.result_block = {pend_word_reg, find.bit_idx};
                        res_next.status       = STAT_DONE;
                        pend_next             = 1'b0;
                        more_next             = 1'b0;
                        state_next            = ST_DONE;
                    end else if (pend_word_reg == last_word) begin
                        res_next.result_block = '0;
                        res_next.status       = STAT_FULL;
                        pend_next             = 1'b0;
                        more_next             = 1'b0;
                        state_next            = ST_DONE;
                    end
                end
            end
            ST_FREE_WR: begin
                map_wr.en   = 1'b1;
                map_wr.data = rd_data & ~(WORD_BITS'(1) << bit_reg);
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_wr_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        map_wr.en |-> (state_reg == ST_SCAN || state_reg == ST_FREE_WR))
        else $error("map written outside scan or free");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("ready right after input transfer");

    a_full_reports_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STAT_FULL) |-> (m_data.result_block == '0))
        else $error("full status with nonzero block");

    a_scan_word_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && pend_reg)
            |-> (pend_word_reg >= first_word && pend_word_reg <= last_word))
        else $error("scan word outside range");

    a_alloc_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && map_wr.en)
            |-> (CFG_W'({pend_word_reg, find.bit_idx}) >= data_start_reg
                 && CFG_W'({pend_word_reg, find.bit_idx}) < lim))
        else $error("allocated block outside range");

endmodule
